// ===== rtl/rgb2g_pkg.sv =====
// Shared types, constants and ROM builders for the RGB to gray converter.
// Depends on nothing; imported by rgb_to_gray_converter, rgb2g_hdtv and the testbench.
package rgb2g_pkg;

  localparam int unsigned GAMMA_INDEX_BITS_DEF = 12;

  typedef enum logic [2:0] {
    GM_MEAN     = 3'd0,
    GM_MIDRANGE = 3'd1,
    GM_MEDIAN   = 3'd2,
    GM_NTSC     = 3'd3,
    GM_HDTV     = 3'd4
  } gray_method_t;

  // floor(x/3) for x <= 765 and floor(x/7) for x <= 1785
  localparam logic [9:0]  MEAN_RECIP = 10'd683;
  localparam logic [13:0] NTSC_RECIP = 14'd9363;

  localparam logic [15:0] W_RED   = 16'd14550;
  localparam logic [15:0] W_GREEN = 16'd46311;
  localparam logic [15:0] W_BLUE  = 16'd4675;

  typedef struct packed {
    logic adv1;
    logic adv2;
  } adv_t;

  typedef logic [255:0] wide_t;
  typedef logic [15:0] lin_rom_t [256];

  function automatic wide_t wpow(input wide_t base, input int unsigned e);
    wide_t acc;
    acc = wide_t'(1);
    for (int unsigned k = 0; k < e; k++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // entry c: largest n with n^5 * 255^11 <= 2^80 * c^11
  function automatic lin_rom_t build_lin_rom();
    lin_rom_t    rom;
    wide_t       k255;
    wide_t       rhs;
    wide_t       lhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    k255 = wpow(wide_t'(255), 11);
    for (int unsigned c = 0; c < 256; c++) begin
      rhs = wpow(wide_t'(c), 11) << 80;
      lo  = 0;
      hi  = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = k255 * wpow(wide_t'(mid), 5);
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      rom[c] = 16'(lo);
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

// ===== rtl/rgb_to_gray_converter.sv =====
// Top level of the RGB to gray converter: stream ports, method register,
// integer rules and pipeline control. Depends on rgb2g_pkg and rgb2g_hdtv.
//
//  channel  direction  ports                    words
//  in       slave      in_tvalid/tready/tdata   one pixel (red, green, blue)
//  out      master     out_tvalid/tready/tdata  one gray level
//  cfg      write-only cfg_we, cfg_wdata        gray_method
//
// One pixel per cycle while out_tready keeps the pipe moving; each pixel passes
// the input register, the product register, the registered read of the
// re-encoding ROM and the output register before out_tvalid.
// Reset clears the stage valids and gray_method (mean).
// Each stage advances when it is empty or the next one advances, so empty
// stages fill while a gray word waits on out_tready.
module rgb_to_gray_converter #(
  parameter int unsigned GAMMA_INDEX_BITS = rgb2g_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,   // gray_method
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata    // gray [7:0]
);
  import rgb2g_pkg::*;

  logic [2:0]  method_r;
  logic        v0_r, v1_r, v2_r, v3_r;
  logic        rdy0, rdy1, rdy2, rdy3;
  logic [7:0]  red_r, green_r, blue_r;
  logic [2:0]  meth0_r;
  logic [7:0]  simple1_r, simple2_r;
  logic        hdtv1_r, hdtv2_r;
  logic [7:0]  gray_r;
  logic [7:0]  hdtv_gray;
  adv_t        adv;

  logic [9:0]  sum3;
  logic [7:0]  hi2, lo2, mx, mn;
  logic [8:0]  mid_sum;
  logic [9:0]  median;
  logic [19:0] mean_prod;
  logic [10:0] ntsc_sum;
  logic [23:0] ntsc_prod;
  logic [7:0]  simple_nxt;
  logic        hdtv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= 3'(GM_MEAN);
    end else if (cfg_we) begin
      method_r <= cfg_wdata;
    end
  end

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign rdy0      = !v0_r || rdy1;
  assign in_tready = rdy0;
  assign adv       = '{adv1: rdy1, adv2: rdy2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_tvalid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      red_r   <= in_tdata[7:0];
      green_r <= in_tdata[15:8];
      blue_r  <= in_tdata[23:16];
      meth0_r <= method_r;
    end
  end

  assign sum3      = 10'(red_r) + 10'(green_r) + 10'(blue_r);
  assign hi2       = (red_r > green_r) ? red_r : green_r;
  assign lo2       = (red_r < green_r) ? red_r : green_r;
  assign mx        = (hi2 > blue_r) ? hi2 : blue_r;
  assign mn        = (lo2 < blue_r) ? lo2 : blue_r;
  assign mid_sum   = 9'(mx) + 9'(mn);
  assign median    = sum3 - 10'(mx) - 10'(mn);
  assign mean_prod = 20'(sum3) * 20'(MEAN_RECIP);
  assign ntsc_sum  = {2'b00, red_r, 1'b0} + {1'b0, green_r, 2'b00} + 11'(blue_r);
  assign ntsc_prod = 24'(ntsc_sum) * 24'(NTSC_RECIP);

  always_comb begin
    simple_nxt = 8'd0;
    hdtv_nxt   = 1'b0;
    unique case (gray_method_t'(meth0_r))
      GM_MEAN:     simple_nxt = mean_prod[18:11];
      GM_MIDRANGE: simple_nxt = mid_sum[8:1];
      GM_MEDIAN:   simple_nxt = median[7:0];
      GM_NTSC:     simple_nxt = ntsc_prod[23:16];
      GM_HDTV:     hdtv_nxt   = 1'b1;
      default:     simple_nxt = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      simple1_r <= simple_nxt;
      hdtv1_r   <= hdtv_nxt;
    end
    if (rdy2) begin
      simple2_r <= simple1_r;
      hdtv2_r   <= hdtv1_r;
    end
    if (rdy3) begin
      gray_r <= hdtv2_r ? hdtv_gray : simple2_r;
    end
  end

  rgb2g_hdtv #(
    .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)
  ) u_hdtv (
    .clk   (clk),
    .adv   (adv),
    .red   (red_r),
    .green (green_r),
    .blue  (blue_r),
    .gray  (hdtv_gray)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = gray_r;

endmodule

// ===== rtl/rgb2g_hdtv.sv =====
// HDTV gamma path: linearising lookup, weighted sum and re-encoding ROM.
// Depends on rgb2g_pkg; instantiated by rgb_to_gray_converter.
module rgb2g_hdtv #(
  parameter int unsigned GAMMA_INDEX_BITS = rgb2g_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  logic              clk,
  input  rgb2g_pkg::adv_t   adv,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic [7:0]        gray
);
  import rgb2g_pkg::*;

  localparam int unsigned ENC_DEPTH = 2 ** GAMMA_INDEX_BITS;

  typedef logic [7:0] enc_rom_t [ENC_DEPTH];

  // entry i: round(255 * (i / ENC_DEPTH)^(5/11)), halves up
  function automatic enc_rom_t build_enc_rom();
    enc_rom_t    rom;
    int unsigned edge_at [256];
    wide_t       k510;
    wide_t       target;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned lvl;
    k510       = wpow(wide_t'(510), 11);
    edge_at[0] = 0;
    for (int unsigned v = 1; v < 256; v++) begin
      target = wpow(wide_t'(2 * v - 1), 11) << (5 * GAMMA_INDEX_BITS);
      lo     = 0;
      hi     = ENC_DEPTH;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (k510 * wpow(wide_t'(mid), 5) >= target) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      edge_at[v] = lo;
    end
    lvl = 0;
    for (int unsigned i = 0; i < ENC_DEPTH; i++) begin
      while (lvl < 255 && edge_at[lvl + 1] <= i) begin
        lvl = lvl + 1;
      end
      rom[i] = 8'(lvl);
    end
    return rom;
  endfunction

  localparam enc_rom_t ENC_ROM = build_enc_rom();

  logic [31:0]                   prod_red_r;
  logic [31:0]                   prod_green_r;
  logic [31:0]                   prod_blue_r;
  logic [33:0]                   sum;
  logic [GAMMA_INDEX_BITS-1:0]   idx;
  logic [7:0]                    gray_r;

  always_ff @(posedge clk) begin
    if (adv.adv1) begin
      prod_red_r   <= 32'(W_RED)   * 32'(LIN_ROM[red]);
      prod_green_r <= 32'(W_GREEN) * 32'(LIN_ROM[green]);
      prod_blue_r  <= 32'(W_BLUE)  * 32'(LIN_ROM[blue]);
    end
  end

  assign sum = 34'(prod_red_r) + 34'(prod_green_r) + 34'(prod_blue_r);
  assign idx = sum[31 -: GAMMA_INDEX_BITS];

  always_ff @(posedge clk) begin
    if (adv.adv2) begin
      gray_r <= ENC_ROM[idx];
    end
  end

  assign gray = gray_r;

endmodule

// ===== rtl/rgb2g_checker.sv =====
// Port-level checks for rgb_to_gray_converter, bound to the top level.
// Depends only on the top level's ports.
module rgb2g_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [2:0]  cfg_wdata,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled gray word changed or dropped");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

bind rgb_to_gray_converter rgb2g_checker u_rgb2g_checker (.*);

// ===== tb/rgb_to_gray_converter_tb.sv =====
// Self-checking testbench for rgb_to_gray_converter: streams pixels through all
// eight method codes and checks each gray word against an in-bench predictor.
// Depends on rgb2g_pkg (method codes) and the rgb_to_gray_converter RTL.
module rgb_to_gray_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgb2g_pkg::*;

  localparam int unsigned INDEX_BITS = 12;
  localparam int unsigned INDEX_SPAN = 1 << INDEX_BITS;
  localparam int          NUM_CODES = 8;
  localparam logic [2:0]  GM_SPARE_LAST = 3'd7;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          WATCHDOG_CYCLES = 2000;
  localparam int          HOLD_OFF_CYCLES = 60;
  localparam int          MAX_REPORTS = 10;
  localparam logic [33:0] WEIGHT_R = 34'd14550;
  localparam logic [33:0] WEIGHT_G = 34'd46311;
  localparam logic [33:0] WEIGHT_B = 34'd4675;
  // corner pixels as {blue, green, red}
  localparam logic [23:0] CORNERS [6] = '{
    24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00, 24'hff0000, 24'h7ffe01
  };

  typedef logic [255:0] big_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red [7:0], green [15:8], blue [23:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // gray [7:0]

  logic [15:0] linear_level [256];
  logic [7:0]  encoded_gray [INDEX_SPAN];
  logic [7:0]  gray_due [$];
  logic [2:0]  method_now;
  bit          tx_idle;
  bit          rx_idle;
  int          rx_hold;
  int          fail_count;
  int          mismatch_count;
  int          words_checked;
  int          pixels_per_method [NUM_CODES];
  int          quiet_cycles;

  rgb_to_gray_converter #(
    .GAMMA_INDEX_BITS(INDEX_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic big_t raise(input big_t base, input int e);
    big_t acc;
    acc = big_t'(1);
    for (int k = 0; k < e; k++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // n^5 * 255^11 <= 2^80 * c^11
  function automatic bit linear_fits(input int c, input int n);
    return raise(big_t'(n), 5) * raise(big_t'(255), 11) <= (raise(big_t'(c), 11) << 80);
  endfunction

  // 510^11 * i^5 >= (2v-1)^11 * 2^(5*bits)
  function automatic bit edge_reached(input int v, input int i);
    return raise(big_t'(510), 11) * raise(big_t'(i), 5) >=
           (raise(big_t'(2 * v - 1), 11) << (5 * INDEX_BITS));
  endfunction

  // estimate in floating point, then settle on the exact integer boundary
  task automatic build_gamma_tables();
    int  n;
    int  i;
    int  level;
    int  edge_at [256];
    real est;
    for (int c = 0; c < 256; c++) begin
      est = 65536.0 * ((c / 255.0) ** 2.2);
      n = int'($floor(est));
      if (n > 65535) n = 65535;
      if (n < 0) n = 0;
      while (n < 65535 && linear_fits(c, n + 1)) n++;
      while (n > 0 && !linear_fits(c, n)) n--;
      linear_level[c] = 16'(n);
    end
    edge_at[0] = 0;
    for (int v = 1; v < 256; v++) begin
      est = INDEX_SPAN * (((2 * v - 1) / 510.0) ** 2.2);
      i = int'($ceil(est));
      if (i > INDEX_SPAN) i = INDEX_SPAN;
      if (i < 0) i = 0;
      while (i > 0 && edge_reached(v, i - 1)) i--;
      while (i < INDEX_SPAN && !edge_reached(v, i)) i++;
      edge_at[v] = i;
    end
    level = 0;
    for (int idx = 0; idx < INDEX_SPAN; idx++) begin
      while (level < 255 && edge_at[level + 1] <= idx) level++;
      encoded_gray[idx] = 8'(level);
    end
  endtask

  function automatic logic [7:0] gray_for(input logic [2:0] method, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b);
    logic [9:0]  total;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [10:0] ntsc;
    logic [33:0] weighted;
    hi = (r > g) ? r : g;
    lo = (r < g) ? r : g;
    if (b > hi) hi = b;
    if (b < lo) lo = b;
    total = 10'(r) + 10'(g) + 10'(b);
    case (method)
      GM_MEAN:     return 8'(total / 10'd3);
      GM_MIDRANGE: return 8'((9'(hi) + 9'(lo)) >> 1);
      GM_MEDIAN:   return 8'(total - 10'(hi) - 10'(lo));
      GM_NTSC: begin
        ntsc = 11'(r) * 11'd2 + 11'(g) * 11'd4 + 11'(b);
        return 8'(ntsc / 11'd7);
      end
      GM_HDTV: begin
        weighted = WEIGHT_R * 34'(linear_level[r]) + WEIGHT_G * 34'(linear_level[g])
                 + WEIGHT_B * 34'(linear_level[b]);
        return encoded_gray[weighted[31 -: INDEX_BITS]];
      end
      default:     return 8'd0;
    endcase
  endfunction

  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    gray_due.push_back(gray_for(method_now, r, g, b));
    pixels_per_method[method_now]++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (gray_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_method(input logic [2:0] method);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= method;
    @(posedge clk);
    cfg_we    <= 1'b0;
    method_now = method;
  endtask

  task automatic push_random_pixel();
    logic [7:0] c [3];
    case ($urandom_range(0, 3))
      0, 1: foreach (c[k]) c[k] = 8'($urandom_range(0, 255));
      2: begin
        c[0] = 8'($urandom_range(0, 255));
        c[1] = c[0];
        c[2] = 8'($urandom_range(0, 255));
        c.shuffle();
      end
      default: foreach (c[k]) c[k] = ($urandom_range(0, 1) ? 8'hfe : 8'h00)
                                   | 8'($urandom_range(0, 1));
    endcase
    push_pixel(c[0], c[1], c[2]);
  endtask

  task automatic test_reset_method();
    tx_idle = 1;
    rx_idle = 1;
    push_pixel(8'd10, 8'd20, 8'd31);
    push_pixel(8'd255, 8'd255, 8'd254);
    settle();
  endtask

  task automatic test_corner_pixels();
    logic [23:0] px;
    for (int k = 0; k < NUM_CODES; k++) begin
      set_method(3'(k));
      for (int j = 0; j < 3; j++) begin
        px = CORNERS[(k * 3 + j) % 6];
        push_pixel(px[7:0], px[15:8], px[23:16]);
      end
    end
  endtask

  task automatic test_random_phases();
    logic [2:0] method;
    for (int p = 0; p < 12; p++) begin
      if (p < NUM_CODES) method = (p == 1) ? GM_HDTV : (p == GM_HDTV) ? 3'(1) : 3'(p);
      else method = ($urandom_range(0, 1) != 0) ? GM_HDTV : 3'($urandom_range(0, 7));
      set_method(method);
      tx_idle = (p % 4 == 0) || (p % 4 == 2);
      rx_idle = (p % 4 == 0) || (p % 4 == 1);
      repeat (80) push_random_pixel();
    end
  endtask

  task automatic test_output_backpressure();
    set_method(GM_HDTV);
    tx_idle = 0;
    rx_idle = 0;
    rx_hold = HOLD_OFF_CYCLES;
    repeat (40) push_random_pixel();
    settle();
    set_method(GM_MEAN);
  endtask

  // gray word checker and receiver pacing
  initial begin
    int         stall;
    logic [7:0] want;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (gray_due.size() == 0) begin
        fail_count++;
        $display("gray word %0d arrived with nothing expected", out_tdata);
      end else begin
        want = gray_due.pop_front();
        words_checked++;
        if (out_tdata !== want) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("gray mismatch: method %0d expected %0d got %0d",
                     method_now, want, out_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = GM_MEAN;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    method_now   = GM_MEAN;
    rx_hold      = 0;
    quiet_cycles = 0;
    foreach (pixels_per_method[k]) pixels_per_method[k] = 0;
    build_gamma_tables();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_method();
    test_corner_pixels();
    test_random_phases();
    test_output_backpressure();

    settle();
    if (gray_due.size() != 0) begin
      fail_count++;
      $display("%0d gray words never arrived", gray_due.size());
    end
    $display("covered: %0d gray words compared over %0d method codes, %0d mismatches",
             words_checked, NUM_CODES, mismatch_count);
    $display("pixels per method 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             pixels_per_method[0], pixels_per_method[1], pixels_per_method[2],
             pixels_per_method[3], pixels_per_method[4], pixels_per_method[5],
             pixels_per_method[6], pixels_per_method[GM_SPARE_LAST]);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rgb2g_pkg.sv
rtl/rgb2g_hdtv.sv
rtl/rgb_to_gray_converter.sv
rtl/rgb2g_checker.sv
tb/rgb_to_gray_converter_tb.sv
